### sv/kts_pkg.sv
// Shared types, codes and helpers of the keyframe sampler.
// Used by kts_tables, kts_slerp and keyframe_trs_sampler; depends on nothing.
`default_nettype none

package kts_pkg;

  localparam int CountWidth = 9;
  localparam int MaxKeys    = 256;

  localparam logic [2:0] ACT_LOAD_TIME  = 3'd0;
  localparam logic [2:0] ACT_LOAD_TRANS = 3'd1;
  localparam logic [2:0] ACT_LOAD_ROT   = 3'd2;
  localparam logic [2:0] ACT_LOAD_SCALE = 3'd3;
  localparam logic [2:0] ACT_QUERY      = 3'd4;

  localparam logic [1:0] COMP_TRANSLATION = 2'd0;
  localparam logic [1:0] COMP_ROTATION    = 2'd1;
  localparam logic [1:0] COMP_SCALE       = 2'd2;

  localparam logic [2:0] CFG_TIME_KEYS  = 3'd0;
  localparam logic [2:0] CFG_TRANS_KEYS = 3'd1;
  localparam logic [2:0] CFG_ROT_KEYS   = 3'd2;
  localparam logic [2:0] CFG_SCALE_KEYS = 3'd3;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  typedef logic [CountWidth-1:0] count_t;

  // Four 32-bit lanes: x,y,z,(unused) or w,x,y,z.
  typedef logic [3:0][31:0] quat_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [7:0]         key_index;
    logic [31:0]        time_value;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic signed [31:0] value_c;
    logic signed [31:0] value_d;
  } item_t;

  typedef struct packed {
    logic [1:0]         component;
    logic signed [31:0] out_a;
    logic signed [31:0] out_b;
    logic signed [31:0] out_c;
    logic signed [31:0] out_d;
    logic               last_result;
  } result_t;

  function automatic logic [31:0] sat33(input logic signed [32:0] v);
    if (v > 33'sh0_7FFF_FFFF) begin
      return 32'h7FFF_FFFF;
    end else if (v < -33'sh0_8000_0000) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] sat64(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      return 32'h7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

### sv/kts_tables.sv
// Key-time memory and key-value memory, each one write and one registered read port.
// Depends on kts_pkg for the value row type.
`default_nettype none

module kts_tables #(
  parameter int AW  = 8,
  parameter int VAW = 10
) (
  input  wire logic               clk,
  input  wire logic               t_we,
  input  wire logic [AW-1:0]      t_waddr,
  input  wire logic [31:0]        t_wdata,
  input  wire logic [AW-1:0]      t_raddr,
  output logic      [31:0]        t_rdata,
  input  wire logic               v_we,
  input  wire logic [VAW-1:0]     v_waddr,
  input  wire kts_pkg::quat_t     v_wdata,
  input  wire logic [VAW-1:0]     v_raddr,
  output kts_pkg::quat_t          v_rdata
);

  localparam int TDepth = 1 << AW;
  localparam int VDepth = 1 << VAW;

  logic [31:0]    time_mem  [TDepth];
  kts_pkg::quat_t value_mem [VDepth];

  always_ff @(posedge clk) begin
    if (t_we) begin
      time_mem[t_waddr] <= t_wdata;
    end
    t_rdata <= time_mem[t_raddr];
  end

  always_ff @(posedge clk) begin
    if (v_we) begin
      value_mem[v_waddr] <= v_wdata;
    end
    v_rdata <= value_mem[v_raddr];
  end

endmodule

`default_nettype wire

### sv/kts_slerp.sv
// Iterative shortest-path quaternion slerp by 30 normalized bisections.
// Depends on kts_pkg; one shared multiplier, a bit-serial square root and four divider lanes.
`default_nettype none

module kts_slerp (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [30:0]    u,
  input  wire kts_pkg::quat_t q0,
  input  wire kts_pkg::quat_t q1,
  output logic                done,
  output kts_pkg::quat_t      r
);

  typedef enum logic [3:0] {
    S_IDLE, S_DOT, S_DOT_LAST, S_SETUP, S_CHECK, S_HALF, S_SQ, S_SQ_LAST,
    S_ROOT, S_DIV_INIT, S_DIV, S_APPLY, S_FIN
  } state_t;

  state_t              state;
  logic [1:0]          lane;
  logic [4:0]          bitn;
  logic [4:0]          cnt;
  logic signed [65:0]  prod;
  logic signed [65:0]  dot;
  logic signed [32:0]  lo [4];
  logic signed [32:0]  hi [4];
  logic signed [32:0]  h  [4];
  logic [63:0]         sq_acc;
  logic [63:0]         x;
  logic [31:0]         root;
  logic [35:0]         rem;
  logic                s_zero;
  logic [31:0]         rem_d [4];
  logic [30:0]         nlo   [4];
  logic [30:0]         q     [4];
  logic                qsat  [4];

  logic signed [33:0]  sum34  [4];
  logic signed [32:0]  h_next [4];
  logic                hneg   [4];
  logic [31:0]         mag    [4];
  logic [60:0]         nfull  [4];
  logic [32:0]         r2     [4];
  logic                ge     [4];
  logic signed [32:0]  qv     [4];
  logic signed [32:0]  mval   [4];
  logic signed [32:0]  q0x    [4];
  logic signed [32:0]  q1x    [4];
  logic [35:0]         remw;
  logic [35:0]         trial;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      q0x[i]    = {q0[i][31], q0[i]};
      q1x[i]    = {q1[i][31], q1[i]};
      sum34[i]  = {lo[i][32], lo[i]} + {hi[i][32], hi[i]};
      h_next[i] = sum34[i][33:1];
      hneg[i]   = h[i][32];
      mag[i]    = hneg[i] ? 32'(-h[i]) : 32'(h[i]);
      nfull[i]  = {mag[i], 29'd0} + 61'(root[31:1]);
      r2[i]     = {rem_d[i], nlo[i][30]};
      ge[i]     = r2[i] >= {1'b0, root};
      qv[i]     = qsat[i] ? 33'sh0_8000_0000 : $signed({2'b00, q[i]});
      mval[i]   = s_zero ? lo[i] : (hneg[i] ? -qv[i] : qv[i]);
    end
    remw  = {rem[33:0], x[63:62]};
    trial = {2'b00, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            lane  <= 2'd0;
            dot   <= '0;
            state <= S_DOT;
          end
        end
        S_DOT: begin
          prod <= $signed(q0[lane]) * $signed(q1[lane]);
          if (lane != 2'd0) begin
            dot <= dot + prod;
          end
          lane <= lane + 2'd1;
          if (lane == 2'd3) begin
            state <= S_DOT_LAST;
          end
        end
        S_DOT_LAST: begin
          dot   <= dot + prod;
          state <= S_SETUP;
        end
        S_SETUP: begin
          // Flip the far key when it lies on the other hemisphere.
          for (int i = 0; i < 4; i++) begin
            lo[i] <= q0x[i];
            hi[i] <= dot[65] ? -q1x[i] : q1x[i];
          end
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (u == '0) begin
            for (int i = 0; i < 4; i++) begin
              r[i] <= kts_pkg::sat33(lo[i]);
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (u >= kts_pkg::ONE_Q30) begin
            for (int i = 0; i < 4; i++) begin
              r[i] <= kts_pkg::sat33(hi[i]);
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            bitn  <= 5'd29;
            state <= S_HALF;
          end
        end
        S_HALF: begin
          for (int i = 0; i < 4; i++) begin
            h[i] <= h_next[i];
          end
          lane   <= 2'd0;
          sq_acc <= '0;
          state  <= S_SQ;
        end
        S_SQ: begin
          prod <= h[lane] * h[lane];
          if (lane != 2'd0) begin
            sq_acc <= sq_acc + 64'(prod[65:2]);
          end
          lane <= lane + 2'd1;
          if (lane == 2'd3) begin
            state <= S_SQ_LAST;
          end
        end
        S_SQ_LAST: begin
          x     <= sq_acc + 64'(prod[65:2]);
          root  <= '0;
          rem   <= '0;
          cnt   <= 5'd31;
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (remw >= trial) begin
            rem  <= remw - trial;
            root <= {root[30:0], 1'b1};
          end else begin
            rem  <= remw;
            root <= {root[30:0], 1'b0};
          end
          x   <= {x[61:0], 2'b00};
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            state <= S_DIV_INIT;
          end
        end
        S_DIV_INIT: begin
          s_zero <= (root == '0);
          for (int i = 0; i < 4; i++) begin
            qsat[i]  <= ({2'b00, nfull[i][60:31]} >= root);
            rem_d[i] <= {2'b00, nfull[i][60:31]};
            nlo[i]   <= nfull[i][30:0];
            q[i]     <= '0;
          end
          cnt <= 5'd30;
          if (root == '0) begin
            state <= S_APPLY;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          for (int i = 0; i < 4; i++) begin
            if (ge[i]) begin
              rem_d[i] <= 32'(r2[i] - {1'b0, root});
            end else begin
              rem_d[i] <= r2[i][31:0];
            end
            q[i]   <= {q[i][29:0], ge[i]};
            nlo[i] <= {nlo[i][29:0], 1'b0};
          end
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          for (int i = 0; i < 4; i++) begin
            if (u[bitn]) begin
              lo[i] <= mval[i];
            end else begin
              hi[i] <= mval[i];
            end
          end
          if (bitn == 5'd0) begin
            state <= S_FIN;
          end else begin
            bitn  <= bitn - 5'd1;
            state <= S_HALF;
          end
        end
        S_FIN: begin
          for (int i = 0; i < 4; i++) begin
            r[i] <= kts_pkg::sat33(lo[i]);
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/keyframe_trs_sampler.sv
// Top level of the keyframe sampler: control sequencer, fraction divider, lerp and output register.
// Depends on kts_pkg, kts_tables and kts_slerp.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-------------------------------
//   item     | item_valid / item_stall | kts_pkg::item_t
//   result   | result_valid / stall    | kts_pkg::result_t
//   config   | cfg_write_en            | cfg_index, cfg_data (9 bits)
//
// A load is written to the key memories as it is accepted. A query walks the time keys, runs the
// fraction divider, then for each present table reads two value rows and holds or lerps them; a
// rotation that is not held runs the bisection loop in place of the lerp, whose square root
// and divider lanes resolve one bit per cycle.
// Reset is synchronous; the key memories are not cleared and read as unknown until loaded.
// A stalled result holds in the output register; the sequencer waits before the next one.
`default_nettype none

module keyframe_trs_sampler (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_stall,
  input  wire kts_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output kts_pkg::result_t      result,
  input  wire logic             cfg_write_en,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [8:0]       cfg_data
);

  localparam int MAX_KEYS = kts_pkg::MaxKeys;
  localparam int AW  = $clog2(MAX_KEYS);
  localparam int VAW = $clog2(3 * MAX_KEYS);
  localparam int CW  = kts_pkg::CountWidth;
  localparam int XW  = ((AW > CW) ? AW : CW) + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_CUR_WAIT, S_CUR, S_NXT_WAIT, S_NXT, S_FRAC, S_DIV, S_COMP,
    S_A_WAIT, S_A, S_B_WAIT, S_B, S_SLERP, S_LMUL, S_LADD, S_EMIT
  } state_t;

  state_t               state;
  kts_pkg::count_t      time_keys, trans_keys, rot_keys, scale_keys;
  logic [AW-1:0]        seg;
  logic [AW-1:0]        taddr;
  logic [VAW-1:0]       vaddr;
  logic [31:0]          t_q, tc, t1, rem;
  logic                 hold;
  logic [30:0]          u;
  logic [4:0]           dcnt;
  logic [1:0]           comp;
  logic [1:0]           lane;
  kts_pkg::quat_t       a_q, b_q, res;
  logic signed [63:0]   prod;
  logic                 slerp_start;

  logic                 accept;
  logic                 key_ok;
  logic [31:0]          t_rdata;
  kts_pkg::quat_t       v_rdata;
  logic                 t_we, v_we;
  logic [AW-1:0]        k_addr;
  logic [1:0]           load_comp;
  kts_pkg::quat_t       load_row;
  logic                 slerp_done;
  kts_pkg::quat_t       slerp_r;
  kts_pkg::count_t      cur_count;
  logic [XW-1:0]        seg_x, n_x, c_x;
  logic [AW-1:0]        seg_start, i0, i1, c_last;
  logic [31:0]          d;
  logic [32:0]          rem2;
  logic signed [32:0]   diff;
  logic signed [63:0]   lerp_sum;
  logic                 last_now;
  logic                 out_free;
  logic [8:0]           cfg_sat;

  function automatic logic [VAW-1:0] row_addr(input logic [1:0] cmp, input logic [AW-1:0] idx);
    return VAW'(cmp) * VAW'(MAX_KEYS) + VAW'(idx);
  endfunction

  always_comb begin
    item_stall = (state != S_IDLE);
    accept     = item_valid && !item_stall;
    key_ok     = ({24'd0, item.key_index} < 32'(MAX_KEYS));
    k_addr     = AW'(item.key_index);
    t_we       = accept && key_ok && (item.action == kts_pkg::ACT_LOAD_TIME);
    v_we       = 1'b0;
    load_comp  = kts_pkg::COMP_TRANSLATION;
    case (item.action)
      kts_pkg::ACT_LOAD_TRANS: begin
        v_we      = accept && key_ok;
        load_comp = kts_pkg::COMP_TRANSLATION;
      end
      kts_pkg::ACT_LOAD_ROT: begin
        v_we      = accept && key_ok;
        load_comp = kts_pkg::COMP_ROTATION;
      end
      kts_pkg::ACT_LOAD_SCALE: begin
        v_we      = accept && key_ok;
        load_comp = kts_pkg::COMP_SCALE;
      end
      default: begin
        v_we = 1'b0;
      end
    endcase
    load_row = {item.value_d, item.value_c, item.value_b, item.value_a};

    case (comp)
      kts_pkg::COMP_TRANSLATION: cur_count = trans_keys;
      kts_pkg::COMP_ROTATION:    cur_count = rot_keys;
      kts_pkg::COMP_SCALE:       cur_count = scale_keys;
      default:                   cur_count = '0;
    endcase

    seg_x     = XW'(seg);
    n_x       = XW'(time_keys);
    c_x       = XW'(cur_count);
    seg_start = (seg_x >= n_x) ? '0 : seg;
    c_last    = AW'(cur_count - kts_pkg::count_t'(1));
    i0        = (seg_x < c_x) ? seg : c_last;
    i1        = (seg_x + XW'(1) < c_x) ? AW'(seg_x + XW'(1)) : c_last;

    d    = t1 - tc;
    rem2 = {rem, 1'b0};

    diff     = $signed({b_q[lane][31], b_q[lane]}) - $signed({a_q[lane][31], a_q[lane]});
    lerp_sum = $signed({{32{a_q[lane][31]}}, a_q[lane]})
             + ((prod + 64'sd536870912) >>> 30);

    last_now = (comp == kts_pkg::COMP_SCALE)
            || ((comp == kts_pkg::COMP_ROTATION) && (scale_keys == '0))
            || ((comp == kts_pkg::COMP_TRANSLATION) && (rot_keys == '0) && (scale_keys == '0));
    out_free = !result_valid || !result_stall;

    cfg_sat = (32'(cfg_data) > 32'(MAX_KEYS)) ? 9'(MAX_KEYS) : cfg_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_keys  <= '0;
      trans_keys <= '0;
      rot_keys   <= '0;
      scale_keys <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        kts_pkg::CFG_TIME_KEYS:  time_keys  <= cfg_sat;
        kts_pkg::CFG_TRANS_KEYS: trans_keys <= cfg_sat;
        kts_pkg::CFG_ROT_KEYS:   rot_keys   <= cfg_sat;
        kts_pkg::CFG_SCALE_KEYS: scale_keys <= cfg_sat;
        default: begin
        end
      endcase
    end
  end

  kts_tables #(
    .AW  (AW),
    .VAW (VAW)
  ) u_tables (
    .clk     (clk),
    .t_we    (t_we),
    .t_waddr (k_addr),
    .t_wdata (item.time_value),
    .t_raddr (taddr),
    .t_rdata (t_rdata),
    .v_we    (v_we),
    .v_waddr (row_addr(load_comp, k_addr)),
    .v_wdata (load_row),
    .v_raddr (vaddr),
    .v_rdata (v_rdata)
  );

  kts_slerp u_slerp (
    .clk   (clk),
    .rst   (rst),
    .start (slerp_start),
    .u     (u),
    .q0    (a_q),
    .q1    (b_q),
    .done  (slerp_done),
    .r     (slerp_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      seg          <= '0;
      result_valid <= 1'b0;
      slerp_start  <= 1'b0;
    end else begin
      if (result_valid && !result_stall && (state != S_EMIT)) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && (item.action == kts_pkg::ACT_QUERY) && (time_keys != '0)) begin
            t_q   <= item.time_value;
            seg   <= seg_start;
            taddr <= seg_start;
            comp  <= kts_pkg::COMP_TRANSLATION;
            state <= S_CUR_WAIT;
          end
        end
        S_CUR_WAIT: begin
          state <= S_CUR;
        end
        S_CUR: begin
          // A sample time before the remembered key restarts the walk at key zero.
          if ((t_rdata > t_q) && (seg != '0)) begin
            seg   <= '0;
            taddr <= '0;
            state <= S_CUR_WAIT;
          end else begin
            tc <= t_rdata;
            if (seg_x + XW'(1) < n_x) begin
              taddr <= AW'(seg_x + XW'(1));
              state <= S_NXT_WAIT;
            end else begin
              hold  <= 1'b1;
              state <= S_FRAC;
            end
          end
        end
        S_NXT_WAIT: begin
          state <= S_NXT;
        end
        S_NXT: begin
          if (t_rdata < tc) begin
            hold  <= 1'b1;
            state <= S_FRAC;
          end else if (t_q < t_rdata) begin
            hold  <= 1'b0;
            t1    <= t_rdata;
            state <= S_FRAC;
          end else begin
            seg <= AW'(seg_x + XW'(1));
            tc  <= t_rdata;
            if (seg_x + XW'(2) < n_x) begin
              taddr <= AW'(seg_x + XW'(2));
              state <= S_NXT_WAIT;
            end else begin
              hold  <= 1'b1;
              state <= S_FRAC;
            end
          end
        end
        S_FRAC: begin
          u <= '0;
          if (hold || (d == '0) || (t_q <= tc)) begin
            state <= S_COMP;
          end else if (t_q >= t1) begin
            u     <= kts_pkg::ONE_Q30;
            state <= S_COMP;
          end else begin
            rem   <= t_q - tc;
            dcnt  <= 5'd29;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem2 >= {1'b0, d}) begin
            rem <= 32'(rem2 - {1'b0, d});
            u   <= {u[29:0], 1'b1};
          end else begin
            rem <= rem2[31:0];
            u   <= {u[29:0], 1'b0};
          end
          dcnt <= dcnt - 5'd1;
          if (dcnt == 5'd0) begin
            state <= S_COMP;
          end
        end
        S_COMP: begin
          if (cur_count == '0) begin
            if (comp == kts_pkg::COMP_SCALE) begin
              state <= S_IDLE;
            end else begin
              comp <= comp + 2'd1;
            end
          end else begin
            vaddr <= row_addr(comp, i0);
            state <= S_A_WAIT;
          end
        end
        S_A_WAIT: begin
          state <= S_A;
        end
        S_A: begin
          a_q   <= v_rdata;
          vaddr <= row_addr(comp, i1);
          state <= S_B_WAIT;
        end
        S_B_WAIT: begin
          state <= S_B;
        end
        S_B: begin
          b_q <= v_rdata;
          if (hold) begin
            res   <= a_q;
            state <= S_EMIT;
          end else if (comp == kts_pkg::COMP_ROTATION) begin
            slerp_start <= 1'b1;
            state       <= S_SLERP;
          end else begin
            lane  <= 2'd0;
            state <= S_LMUL;
          end
        end
        S_SLERP: begin
          slerp_start <= 1'b0;
          if (slerp_done) begin
            res   <= slerp_r;
            state <= S_EMIT;
          end
        end
        S_LMUL: begin
          prod  <= diff * $signed({1'b0, u});
          state <= S_LADD;
        end
        S_LADD: begin
          res[lane] <= kts_pkg::sat64(lerp_sum);
          if (lane == 2'd2) begin
            state <= S_EMIT;
          end else begin
            lane  <= lane + 2'd1;
            state <= S_LMUL;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            result_valid       <= 1'b1;
            result.component   <= comp;
            result.out_a       <= $signed(res[0]);
            result.out_b       <= $signed(res[1]);
            result.out_c       <= $signed(res[2]);
            result.out_d       <= (comp == kts_pkg::COMP_ROTATION) ? $signed(res[3]) : '0;
            result.last_result <= last_now;
            if (last_now) begin
              state <= S_IDLE;
            end else begin
              comp  <= comp + 2'd1;
              state <= S_COMP;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_slerp_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    slerp_done |-> (state == S_SLERP))
    else $error("slerp unit finished while the sequencer was not waiting for it");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EMIT) && out_free && last_now) |=> (state == S_IDLE))
    else $error("sequencer did not return to idle after the final result");

  a_fraction_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMP) |-> (u <= kts_pkg::ONE_Q30))
    else $error("interpolation fraction exceeds one");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FRAC) |-> (seg_x < n_x))
    else $error("segment index beyond the loaded key count");

endmodule

`default_nettype wire

### tb/sv/keyframe_trs_sampler_tb.sv
// Self-checking testbench for keyframe_trs_sampler: loads keyframe tables, issues sample
// queries and checks every translation, rotation and scale result against its own predictor.
// Depends on kts_pkg and the keyframe_trs_sampler RTL.
`timescale 1ns / 1ps

module keyframe_trs_sampler_tb;

  typedef logic signed [63:0] s64;

  localparam int  NumSlots = kts_pkg::MaxKeys;
  localparam int  HoldCycles = 6000;
  localparam int  DrainCycles = 2500;
  localparam s64  Q30One = s64'(kts_pkg::ONE_Q30);

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             item_valid = 1'b0;
  logic             item_stall;
  kts_pkg::item_t   item = '0;
  logic             result_valid;
  logic             result_stall = 1'b1;
  kts_pkg::result_t result;
  logic             cfg_write_en = 1'b0;
  logic [2:0]       cfg_index = kts_pkg::CFG_TIME_KEYS;
  logic [8:0]       cfg_data = '0;

  keyframe_trs_sampler uut (
    .clk, .rst, .item_valid, .item_stall, .item, .result_valid, .result_stall, .result,
    .cfg_write_en, .cfg_index, .cfg_data
  );

  always #5 clk = ~clk;

  // Predictor state.
  logic [31:0] key_time [NumSlots];
  logic [31:0] trans_key [NumSlots][3];
  logic [31:0] rot_key [NumSlots][4];
  logic [31:0] scale_key [NumSlots][3];
  int          cur_segment = 0;
  int          key_count [4] = '{0, 0, 0, 0};

  kts_pkg::result_t expected_results [$];
  kts_pkg::item_t   pending_items [$];
  logic [31:0] plan_time [9];
  int          mismatches = 0;
  bit          quiet = 1'b0;
  bit          item_taken = 1'b0;
  int          send_gap = 0;
  int          recv_gap = 0;
  int          hold_left = 0;
  int          holds_asked = 0;
  int          holds_served = 0;

  function automatic logic [31:0] clip32(s64 v);
    if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] root64(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] probe;
    r = '0;
    probe = 64'd1 << 62;
    while (probe > x) probe >>= 2;
    while (probe != 0) begin
      if (x >= r + probe) begin
        x -= r + probe;
        r = (r >> 1) + probe;
      end else begin
        r >>= 1;
      end
      probe >>= 2;
    end
    return r;
  endfunction

  function automatic s64 blend(logic [31:0] a, logic [31:0] b, s64 u);
    s64 sa, p;
    sa = s64'(signed'(a));
    p = (s64'(signed'(b)) - sa) * u;
    return sa + ((p + (64'sd1 <<< 29)) >>> 30);
  endfunction

  // Works out the results of one accepted transaction and queues them.
  function automatic void sample_pose(kts_pkg::item_t it);
    int n, seg, c, i0, i1, comp, j, b;
    bit hold;
    s64 u;
    logic [31:0] t0, t1, span;
    logic [63:0] num, acc, s, mag, qv;
    logic signed [65:0] dot;
    s64 qa [4], qb [4], lo [4], hi [4], m [4], h [4];
    kts_pkg::result_t res;
    kts_pkg::result_t found [$];
    logic [1:0] comp_code [3];
    comp_code = '{kts_pkg::COMP_TRANSLATION, kts_pkg::COMP_ROTATION, kts_pkg::COMP_SCALE};
    if (it.action <= kts_pkg::ACT_LOAD_SCALE) begin
      case (it.action)
        kts_pkg::ACT_LOAD_TIME: key_time[it.key_index] = it.time_value;
        kts_pkg::ACT_LOAD_TRANS:
          trans_key[it.key_index] = '{it.value_a, it.value_b, it.value_c};
        kts_pkg::ACT_LOAD_ROT:
          rot_key[it.key_index] = '{it.value_a, it.value_b, it.value_c, it.value_d};
        default: scale_key[it.key_index] = '{it.value_a, it.value_b, it.value_c};
      endcase
      return;
    end
    if (it.action != kts_pkg::ACT_QUERY) return;
    n = key_count[kts_pkg::CFG_TIME_KEYS];
    if (n == 0) return;
    seg = cur_segment;
    if (seg >= n || key_time[seg] > it.time_value) seg = 0;
    while (seg + 1 < n) begin
      if (key_time[seg + 1] < key_time[seg] || it.time_value < key_time[seg + 1]) break;
      seg++;
    end
    cur_segment = seg;
    hold = (seg + 1 >= n) || (key_time[seg + 1] < key_time[seg]);
    u = 0;
    if (!hold) begin
      t0 = key_time[seg];
      t1 = key_time[seg + 1];
      span = t1 - t0;
      if (span == 0 || it.time_value <= t0) u = 0;
      else if (it.time_value >= t1) u = Q30One;
      else begin
        num = {32'd0, it.time_value - t0} << 30;
        u = s64'(num / {32'd0, span});
      end
    end
    for (comp = 0; comp < 3; comp++) begin
      c = key_count[comp + 1];
      if (c == 0) continue;
      i0 = (seg < c) ? seg : c - 1;
      i1 = (seg + 1 < c) ? seg + 1 : c - 1;
      res = '0;
      res.component = comp_code[comp];
      if (comp_code[comp] == kts_pkg::COMP_ROTATION) begin
        dot = 0;
        for (j = 0; j < 4; j++) begin
          qa[j] = s64'(signed'(rot_key[i0][j]));
          qb[j] = s64'(signed'(rot_key[i1][j]));
          dot += qa[j] * qb[j];
        end
        // Take the shorter arc: flip the far key when the two point apart.
        for (j = 0; j < 4; j++) begin
          lo[j] = qa[j];
          hi[j] = (dot < 0) ? -qb[j] : qb[j];
        end
        if (!hold && u >= Q30One) begin
          lo = hi;
        end else if (!hold && u > 0) begin
          for (b = 29; b >= 0; b--) begin
            acc = '0;
            for (j = 0; j < 4; j++) begin
              h[j] = (lo[j] + hi[j]) >>> 1;
              acc += (h[j] * h[j]) >> 2;
            end
            s = root64(acc);
            if (s == 0) begin
              m = lo;
            end else begin
              for (j = 0; j < 4; j++) begin
                mag = (h[j] < 0) ? -h[j] : h[j];
                qv = ((mag << 29) + (s >> 1)) / s;
                if (qv > (64'd1 << 31)) qv = 64'd1 << 31;
                m[j] = (h[j] < 0) ? -s64'(qv) : s64'(qv);
              end
            end
            if (u[b]) lo = m;
            else hi = m;
          end
        end
        if (hold) for (j = 0; j < 4; j++) lo[j] = qa[j];
        res.out_a = clip32(lo[0]);
        res.out_b = clip32(lo[1]);
        res.out_c = clip32(lo[2]);
        res.out_d = clip32(lo[3]);
      end else if (comp_code[comp] == kts_pkg::COMP_TRANSLATION) begin
        res.out_a = hold ? trans_key[i0][0] : clip32(blend(trans_key[i0][0], trans_key[i1][0], u));
        res.out_b = hold ? trans_key[i0][1] : clip32(blend(trans_key[i0][1], trans_key[i1][1], u));
        res.out_c = hold ? trans_key[i0][2] : clip32(blend(trans_key[i0][2], trans_key[i1][2], u));
      end else begin
        res.out_a = hold ? scale_key[i0][0] : clip32(blend(scale_key[i0][0], scale_key[i1][0], u));
        res.out_b = hold ? scale_key[i0][1] : clip32(blend(scale_key[i0][1], scale_key[i1][1], u));
        res.out_c = hold ? scale_key[i0][2] : clip32(blend(scale_key[i0][2], scale_key[i1][2], u));
      end
      found.push_back(res);
    end
    if (found.size() > 0) found[found.size() - 1].last_result = 1'b1;
    foreach (found[j]) expected_results.push_back(found[j]);
  endfunction

  // Acceptance, prediction and result checking at the rising edge.
  always @(posedge clk) begin
    kts_pkg::result_t want;
    if (rst) begin
      item_taken <= 1'b0;
    end else begin
      item_taken <= item_valid && !item_stall;
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", result);
        end else begin
          want = expected_results.pop_front();
          if (result.component !== want.component || result.out_a !== want.out_a ||
              result.out_b !== want.out_b || result.out_c !== want.out_c ||
              result.out_d !== want.out_d || result.last_result !== want.last_result) begin
            mismatches++;
            if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, result);
          end
        end
      end
      if (item_valid && !item_stall) sample_pose(item);
    end
  end

  // Sender: offers the next pending transaction, with random gaps.
  always @(negedge clk) begin
    if (!rst && (!item_valid || item_taken)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        item_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        item <= pending_items.pop_front();
        item_valid <= 1'b1;
        if (!quiet && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 15);
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, plus long holds on request.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_stall <= 1'b1;
    end else if (holds_asked != holds_served) begin
      holds_served <= holds_asked;
      hold_left <= HoldCycles;
      result_stall <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      result_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      recv_gap <= $urandom_range(0, 14);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  task automatic push(logic [2:0] act, logic [7:0] k, logic [31:0] t,
                      logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d);
    kts_pkg::item_t it;
    it = '{action: act, key_index: k, time_value: t, value_a: a, value_b: b, value_c: c,
           value_d: d};
    pending_items.push_back(it);
  endtask

  function automatic logic [31:0] unit_part();
    return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
  endfunction

  task automatic load_values(logic [7:0] k);
    push(kts_pkg::ACT_LOAD_TRANS, k, $urandom, $urandom, $urandom, $urandom, $urandom);
    if ($urandom_range(0, 2) == 0)
      push(kts_pkg::ACT_LOAD_ROT, k, $urandom, $urandom, $urandom, $urandom, $urandom);
    else
      push(kts_pkg::ACT_LOAD_ROT, k, $urandom, unit_part(), unit_part(), unit_part(),
           unit_part());
    push(kts_pkg::ACT_LOAD_SCALE, k, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Times for slots 0..8: ascending, optionally with repeats, a loop point,
  // or a last key at the top of the range.
  task automatic load_times(int loop_slot, bit repeats, bit top_last);
    for (int i = 0; i < 9; i++) begin
      if (i == 0) plan_time[i] = $urandom_range(0, 1000);
      else if (repeats && $urandom_range(0, 2) == 0) plan_time[i] = plan_time[i - 1];
      else plan_time[i] = plan_time[i - 1] + $urandom_range(1, 32'h3_0000);
      if (i == loop_slot) plan_time[i] = plan_time[i - 1] / 2;
      if (top_last && i == 8) plan_time[i] = 32'hFFFF_FFFF;
      push(kts_pkg::ACT_LOAD_TIME, i, plan_time[i], $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic query(logic [31:0] t);
    push(kts_pkg::ACT_QUERY, $urandom, t, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Mostly queries near the loaded keys; some loads and ignored actions.
  task automatic random_mix(int count, bit cap_top);
    logic [31:0] t;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        case ($urandom_range(0, 3))
          0: t = $urandom;
          1: t = plan_time[$urandom_range(0, 8)];
          2: t = plan_time[$urandom_range(0, 7)] + $urandom_range(0, 32'h3_0000);
          default: t = plan_time[$urandom_range(0, 8)] + $urandom_range(0, 2) - 1;
        endcase
        if (cap_top && t == 32'hFFFF_FFFF) t = 32'hFFFF_FFFE;
        query(t);
      end else if (pick < 17) begin
        load_values($urandom_range(0, 255));
      end else if (pick < 19) begin
        push(kts_pkg::ACT_LOAD_TIME, $urandom_range(9, 255), $urandom, $urandom, $urandom,
             $urandom, $urandom);
      end else begin
        push($urandom_range(kts_pkg::ACT_QUERY + 1, 7), $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom);
      end
    end
  endtask

  // Register writes wait until the block is idle and no transaction is pending.
  task automatic write_reg(logic [2:0] idx, logic [8:0] value);
    @(negedge clk);
    while (pending_items.size() != 0 || item_valid || item_stall) @(negedge clk);
    cfg_write_en = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    if (idx <= kts_pkg::CFG_SCALE_KEYS) key_count[idx] = (value > 256) ? 256 : value;
    @(negedge clk);
    cfg_write_en = 1'b0;
  endtask

  task automatic write_counts(logic [8:0] nt, logic [8:0] ntr, logic [8:0] nr, logic [8:0] ns);
    write_reg(kts_pkg::CFG_TIME_KEYS, nt);
    write_reg(kts_pkg::CFG_TRANS_KEYS, ntr);
    write_reg(kts_pkg::CFG_ROT_KEYS, nr);
    write_reg(kts_pkg::CFG_SCALE_KEYS, ns);
  endtask

  // Waits until every transaction is taken and every result has come, then lets
  // a query that produces no result run out.
  task automatic drain();
    do @(posedge clk);
    while (pending_items.size() != 0 || item_valid || expected_results.size() != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Tables while the channel is off: extreme values, ignored actions, a silent query.
    load_times(-1, 1'b0, 1'b0);
    push(kts_pkg::ACT_LOAD_TRANS, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
    push(kts_pkg::ACT_LOAD_ROT, 0, 0, 32'h4000_0000, 0, 0, 0);
    push(kts_pkg::ACT_LOAD_SCALE, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
    push(kts_pkg::ACT_LOAD_TRANS, 1, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
    push(kts_pkg::ACT_LOAD_ROT, 1, 0, 32'hC000_0000, 0, 0, 0);
    push(kts_pkg::ACT_LOAD_SCALE, 1, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0);
    for (int k = 2; k < 9; k++) load_values(k);
    load_values(255);
    push(5, 3, 0, 0, 0, 0, 0);
    push(6, 0, 0, 0, 0, 0, 0);
    push(7, 255, 32'hFFFF_FFFF, -1, -1, -1, -1);
    query(plan_time[3]);
    drain();

    // Full tables: below the first key, on keys, between keys, at the end, backwards.
    write_counts(9, 9, 9, 9);
    query(0);
    query(plan_time[0]);
    query(plan_time[1]);
    query(plan_time[1] + (plan_time[2] - plan_time[1]) / 2);
    query(plan_time[8]);
    query(32'hFFFF_FFFF);
    query(plan_time[2] + 1);
    random_mix(20, 1'b0);
    drain();

    // Two keys; translation table shorter, rotation table empty, scale table longer than the time table.
    write_counts(2, 1, 0, 3);
    random_mix(20, 1'b0);
    drain();

    // Loop point and repeated times; first no value tables at all.
    load_times(5, 1'b1, 1'b0);
    write_counts(9, 0, 0, 0);
    for (int i = 0; i < 6; i++) query(plan_time[$urandom_range(0, 8)]);
    drain();
    write_counts(9, 4, 9, 2);
    holds_asked++;
    random_mix(24, 1'b0);
    drain();

    // Largest counts, with an oversized write that saturates and ignored register indexes.
    load_times(-1, 1'b0, 1'b1);
    write_counts(511, 256, 256, 256);
    write_reg(3'd4, $urandom);
    write_reg(3'd7, 9'h1FF);
    random_mix(20, 1'b1);
    drain();

    // Channel off again, then a calm final stretch with no idling.
    write_reg(kts_pkg::CFG_TIME_KEYS, 0);
    query(plan_time[2]);
    query(32'hFFFF_FFFF);
    drain();
    quiet = 1'b1;
    load_times(-1, 1'b1, 1'b0);
    write_counts(9, 9, 9, 9);
    random_mix(25, 1'b0);
    drain();

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
sv/kts_pkg.sv
sv/kts_tables.sv
sv/kts_slerp.sv
sv/keyframe_trs_sampler.sv
tb/sv/keyframe_trs_sampler_tb.sv
